// File: rtl/multi_server_queue_dispatch_assert.svh
// Assertion macros shared by the checker.
`ifndef MULTI_SERVER_QUEUE_DISPATCH_ASSERT_SVH
`define MULTI_SERVER_QUEUE_DISPATCH_ASSERT_SVH

// Same-cycle implication.
`define MSQD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MSQD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/msqd_pkg.sv
package msqd_pkg;

  localparam int CFG_DATA_W = 11;
  localparam int CFG_IDX_W  = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SERVERS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_QUEUE_DEPTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OPEN_TIME   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_TIME  = 2'd3;

  localparam logic [4:0]  NUM_SERVERS_RESET = 5'd1;
  localparam logic [4:0]  QUEUE_DEPTH_RESET = 5'd1;
  localparam logic [10:0] OPEN_RESET        = 11'd480;
  localparam logic [10:0] CLOSE_RESET       = 11'd1020;

  localparam int SERVICE_W = 10;
  localparam int INDEX_W   = 4;
  localparam int OUT_TIME_W = 16;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_DECIDE,
    ST_DIV,
    ST_SCAN,
    ST_RR_FIN,
    ST_RR_REL,
    ST_POP_FIN,
    ST_POP_RD,
    ST_POP_REL,
    ST_OUT
  } msqd_state_t;

  typedef enum logic {
    ALU_ADD_SAT,
    ALU_SUB
  } alu_op_t;

endpackage

// File: rtl/msqd_ram.sv
module msqd_ram #(
  parameter int WIDTH = 10,
  parameter int DEPTH = 256
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/msqd_alu.sv
module msqd_alu
  import msqd_pkg::*;
#(
  parameter int W = 16
) (
  input  alu_op_t        op,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [W-1:0]   res,
  output logic           flag
);

  logic [W:0] ext;

  // add: flag is overflow, result saturates; sub: flag is borrow (a < b)
  always_comb begin
    if (op == ALU_ADD_SAT) begin
      ext = {1'b0, a} + {1'b0, b};
      res = ext[W] ? '1 : ext[W-1:0];
    end else begin
      ext = {1'b0, a} - {1'b0, b};
      res = ext[W-1:0];
    end
    flag = ext[W];
  end

endmodule

// File: rtl/multi_server_queue_dispatch.sv
// Job dispatcher over up to MAX_SERVERS servers, each with a bounded ring of queued
// service times. One word in, one word out; the block takes no new word until the
// result has been taken. While the batch fills, a job is placed round-robin: the job
// count is divided by num_servers one quotient bit per cycle, and the remainder picks
// the server. Once the queues are full, the earliest head release is found by visiting
// one server per cycle. A word with new_batch set first passes a clearing state that
// resets the server state. The divider steps, head-release compares and time sums go
// through one shared add/subtract unit; queued times live in one RAM.
module multi_server_queue_dispatch
  import msqd_pkg::*;
#(
  parameter int MAX_SERVERS = 16,
  parameter int MAX_QUEUE   = 16,
  parameter int TIME_BITS   = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  new_batch,
  input  logic [SERVICE_W-1:0]  service_time,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [INDEX_W-1:0]    server_index,
  output logic [OUT_TIME_W-1:0] start_time,
  output logic [OUT_TIME_W-1:0] finish_time,
  output logic                  refused,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int SW = (MAX_SERVERS > 1) ? $clog2(MAX_SERVERS) : 1;
  localparam int QW = (MAX_QUEUE > 1) ? $clog2(MAX_QUEUE) : 1;
  localparam int NW = $clog2(MAX_SERVERS + 1);
  localparam int MW = $clog2(MAX_QUEUE + 1);
  localparam int JW = ($clog2(MAX_SERVERS * MAX_QUEUE + 1) > 1) ?
                      $clog2(MAX_SERVERS * MAX_QUEUE + 1) : 2;
  localparam int CW = $clog2(JW);
  localparam int TB = TIME_BITS;
  localparam int RamDepth = 1 << (SW + QW);

  msqd_state_t state, state_next;

  logic [4:0]  num_servers;
  logic [4:0]  queue_depth;
  logic [10:0] open_time;
  logic [10:0] close_time;

  logic [TB-1:0] server_finish [MAX_SERVERS];
  logic [TB-1:0] head_release  [MAX_SERVERS];
  logic [QW-1:0] queue_head_ptr [MAX_SERVERS];
  logic [JW-1:0] jobs_admitted;

  logic [SERVICE_W-1:0] svc;
  logic [JW-1:0] div_dvd;
  logic [NW-1:0] div_rem;
  logic [JW-1:0] div_quo;
  logic [CW-1:0] div_cnt;
  logic [NW-1:0] idx;
  logic [SW-1:0] sel;
  logic [TB-1:0] best_val;
  logic [QW-1:0] head_new;

  logic [NW-1:0] n_eff;
  logic [MW-1:0] m_eff;
  logic          rr_phase;
  logic          scan_done;
  logic          div_last;
  logic [NW:0]   trial;
  logic [NW-1:0] rem_new;
  logic [SW-1:0] hr_addr;
  logic [TB-1:0] hr_rd;
  logic [QW-1:0] rr_slot;
  logic [QW-1:0] pop_slot;
  logic [QW-1:0] pop_head;

  alu_op_t       alu_op;
  logic [TB-1:0] alu_a;
  logic [TB-1:0] alu_b;
  logic [TB-1:0] alu_res;
  logic          alu_flag;

  logic                  ram_we;
  logic [SW+QW-1:0]      ram_waddr;
  logic [SERVICE_W-1:0]  ram_rdata;

  function automatic logic [QW-1:0] ring_wrap(input logic [QW:0] v);
    if (32'(v) >= MAX_QUEUE) begin
      return QW'(32'(v) - MAX_QUEUE);
    end
    return v[QW-1:0];
  endfunction

  always_comb begin
    if (num_servers == '0) begin
      n_eff = NW'(1);
    end else if (32'(num_servers) > MAX_SERVERS) begin
      n_eff = NW'(MAX_SERVERS);
    end else begin
      n_eff = NW'(num_servers);
    end
    if (queue_depth == '0) begin
      m_eff = MW'(1);
    end else if (32'(queue_depth) > MAX_QUEUE) begin
      m_eff = MW'(MAX_QUEUE);
    end else begin
      m_eff = MW'(queue_depth);
    end
  end

  assign rr_phase  = 32'(jobs_admitted) < (32'(n_eff) * 32'(m_eff));
  assign scan_done = 32'(idx) >= 32'(n_eff);
  assign div_last  = (div_cnt == CW'(JW - 1));
  assign trial     = {div_rem, div_dvd[JW-1]};
  assign rem_new   = alu_flag ? NW'(trial) : NW'(alu_res);

  always_comb begin
    if (state == ST_SCAN) begin
      hr_addr = idx[SW-1:0];
    end else if (state == ST_DECIDE) begin
      hr_addr = '0;
    end else begin
      hr_addr = sel;
    end
  end
  assign hr_rd = head_release[hr_addr];

  assign rr_slot  = ring_wrap({1'b0, queue_head_ptr[sel]} + (QW+1)'(div_quo));
  assign pop_slot = ring_wrap({1'b0, queue_head_ptr[sel]} + (QW+1)'(m_eff));
  assign pop_head = ring_wrap({1'b0, queue_head_ptr[sel]} + (QW+1)'(1));

  always_comb begin
    alu_op = ALU_ADD_SAT;
    alu_a  = '0;
    alu_b  = '0;
    case (state)
      ST_DIV: begin
        alu_op = ALU_SUB;
        alu_a  = TB'(trial);
        alu_b  = TB'(n_eff);
      end
      ST_SCAN: begin
        alu_op = ALU_SUB;
        alu_a  = hr_rd;
        alu_b  = best_val;
      end
      ST_RR_FIN, ST_POP_FIN: begin
        alu_a = server_finish[sel];
        alu_b = TB'(svc);
      end
      ST_RR_REL: begin
        alu_a = hr_rd;
        alu_b = TB'(svc);
      end
      ST_POP_REL: begin
        alu_a = hr_rd;
        alu_b = TB'(ram_rdata);
      end
      default: begin
        alu_op = ALU_ADD_SAT;
      end
    endcase
  end

  msqd_alu #(.W(TB)) u_alu (
    .op   (alu_op),
    .a    (alu_a),
    .b    (alu_b),
    .res  (alu_res),
    .flag (alu_flag)
  );

  assign ram_we    = (state == ST_RR_FIN) || (state == ST_POP_FIN);
  assign ram_waddr = (state == ST_RR_FIN) ? {sel, rr_slot} : {sel, pop_slot};

  msqd_ram #(.WIDTH(SERVICE_W), .DEPTH(RamDepth)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (svc),
    .raddr ({sel, head_new}),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:    if (in_valid) state_next = new_batch ? ST_CLEAR : ST_DECIDE;
      ST_CLEAR:   state_next = ST_DECIDE;
      ST_DECIDE:  state_next = rr_phase ? ST_DIV : ST_SCAN;
      ST_DIV:     if (div_last) state_next = ST_RR_FIN;
      ST_SCAN:    if (scan_done) state_next = ST_POP_FIN;
      ST_RR_FIN:  state_next = ST_RR_REL;
      ST_RR_REL:  state_next = ST_OUT;
      ST_POP_FIN: state_next = ST_POP_RD;
      ST_POP_RD:  state_next = ST_POP_REL;
      ST_POP_REL: state_next = ST_OUT;
      ST_OUT:     if (out_ready) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == ST_IDLE);
    out_valid = (state == ST_OUT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      num_servers   <= NUM_SERVERS_RESET;
      queue_depth   <= QUEUE_DEPTH_RESET;
      open_time     <= OPEN_RESET;
      close_time    <= CLOSE_RESET;
      jobs_admitted <= '0;
      for (int s = 0; s < MAX_SERVERS; s++) begin
        server_finish[s]  <= TB'(OPEN_RESET);
        head_release[s]   <= TB'(OPEN_RESET);
        queue_head_ptr[s] <= '0;
      end
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_SERVERS: num_servers <= cfg_data[4:0];
          CFG_QUEUE_DEPTH: queue_depth <= cfg_data[4:0];
          CFG_OPEN_TIME:   open_time   <= cfg_data;
          CFG_CLOSE_TIME:  close_time  <= cfg_data;
          default:         num_servers <= num_servers;
        endcase
      end
      case (state)
        ST_CLEAR: begin
          jobs_admitted <= '0;
          for (int s = 0; s < MAX_SERVERS; s++) begin
            server_finish[s]  <= TB'(open_time);
            head_release[s]   <= TB'(open_time);
            queue_head_ptr[s] <= '0;
          end
        end
        ST_RR_FIN: begin
          server_finish[sel] <= alu_res;
          jobs_admitted      <= jobs_admitted + JW'(1);
        end
        ST_RR_REL: begin
          if (div_quo == '0) head_release[sel] <= alu_res;
        end
        ST_POP_FIN: begin
          server_finish[sel]  <= alu_res;
          queue_head_ptr[sel] <= pop_head;
        end
        ST_POP_REL: begin
          head_release[sel] <= alu_res;
        end
        default: begin
          jobs_admitted <= jobs_admitted;
        end
      endcase
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        svc <= service_time;
      end
      ST_DECIDE: begin
        div_dvd  <= jobs_admitted;
        div_rem  <= '0;
        div_quo  <= '0;
        div_cnt  <= '0;
        sel      <= '0;
        best_val <= hr_rd;
        idx      <= NW'(1);
      end
      ST_DIV: begin
        div_dvd <= {div_dvd[JW-2:0], 1'b0};
        div_rem <= rem_new;
        div_quo <= {div_quo[JW-2:0], ~alu_flag};
        div_cnt <= div_cnt + CW'(1);
        if (div_last) sel <= SW'(rem_new);
      end
      ST_SCAN: begin
        if (!scan_done) begin
          if (alu_flag) begin
            sel      <= idx[SW-1:0];
            best_val <= hr_rd;
          end
          idx <= idx + NW'(1);
        end
      end
      ST_RR_FIN, ST_POP_FIN: begin
        server_index <= INDEX_W'(sel);
        start_time   <= OUT_TIME_W'(server_finish[sel]);
        finish_time  <= OUT_TIME_W'(alu_res);
        refused      <= server_finish[sel] >= TB'(close_time);
        if (state == ST_POP_FIN) head_new <= pop_head;
      end
      default: begin
        svc <= svc;
      end
    endcase
  end

endmodule

// File: rtl/msqd_checker.sv
module msqd_checker
  import msqd_pkg::*;
(
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [INDEX_W-1:0]    server_index,
  input logic [OUT_TIME_W-1:0] start_time,
  input logic [OUT_TIME_W-1:0] finish_time,
  input logic                  refused
);

`include "multi_server_queue_dispatch_assert.svh"

  `MSQD_ASSERT_NEXT(a_busy_after_accept, clk, rst,
    in_valid && in_ready, !in_ready, "word taken while busy")
  `MSQD_ASSERT_NOW(a_no_take_with_result, clk, rst,
    out_valid, !in_ready, "input open with result pending")
  `MSQD_ASSERT_NOW(a_finish_order, clk, rst,
    out_valid, finish_time >= start_time, "finish before start")
  `MSQD_ASSERT_NEXT(a_out_hold, clk, rst,
    out_valid && !out_ready,
    out_valid && $stable(server_index) && $stable(start_time) &&
    $stable(finish_time) && $stable(refused),
    "result word dropped")

endmodule

bind multi_server_queue_dispatch msqd_checker u_msqd_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .server_index (server_index),
  .start_time   (start_time),
  .finish_time  (finish_time),
  .refused      (refused)
);

// File: dv/msqd_dispatch_checker.sv
module msqd_dispatch_checker
  import msqd_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  in_ready,
  input  logic                  new_batch,
  input  logic [SERVICE_W-1:0]  service_time,
  input  logic                  out_valid,
  input  logic                  out_ready,
  input  logic [INDEX_W-1:0]    server_index,
  input  logic [OUT_TIME_W-1:0] start_time,
  input  logic [OUT_TIME_W-1:0] finish_time,
  input  logic                  refused,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatches,
  output int unsigned           outstanding
);

  localparam int SERVERS = 16;
  localparam int RING = 16;
  localparam logic [15:0] TIME_CEIL = 16'hFFFF;

  typedef struct packed {
    logic [INDEX_W-1:0]    server;
    logic [OUT_TIME_W-1:0] start;
    logic [OUT_TIME_W-1:0] finish;
    logic                  refused;
  } dispatch_t;

  logic [4:0]           reg_servers;
  logic [4:0]           reg_depth;
  logic [10:0]          reg_open;
  logic [10:0]          reg_close;
  logic [15:0]          busy_until [SERVERS];
  logic [15:0]          head_leaves [SERVERS];
  logic [SERVICE_W-1:0] ring_times [SERVERS][RING];
  logic [3:0]           head_slot [SERVERS];
  int unsigned          admitted;
  dispatch_t            expected_dispatch [$];

  function automatic logic [15:0] add_sat(logic [15:0] a, logic [15:0] b);
    logic [16:0] sum;
    sum = {1'b0, a} + {1'b0, b};
    return sum[16] ? TIME_CEIL : sum[15:0];
  endfunction

  function automatic void clear_servers(logic [15:0] t0);
    for (int s = 0; s < SERVERS; s++) begin
      busy_until[s] = t0;
      head_leaves[s] = t0;
      head_slot[s] = '0;
      for (int i = 0; i < RING; i++) ring_times[s][i] = '0;
    end
    admitted = 0;
  endfunction

  function automatic dispatch_t dispatch_job(logic batch, logic [SERVICE_W-1:0] svc);
    int n, m, s, slot, h;
    dispatch_t r;
    n = (reg_servers == 0) ? 1 : (reg_servers > SERVERS) ? SERVERS : int'(reg_servers);
    m = (reg_depth == 0) ? 1 : (reg_depth > RING) ? RING : int'(reg_depth);
    if (batch) clear_servers({5'd0, reg_open});
    if (admitted < n * m) begin
      // fill phase: round-robin
      s = admitted % n;
      slot = (head_slot[s] + admitted / n) % RING;
      ring_times[s][slot] = svc;
      r.start = busy_until[s];
      busy_until[s] = add_sat(r.start, {6'd0, svc});
      if (admitted < n) head_leaves[s] = add_sat(head_leaves[s], {6'd0, svc});
      admitted++;
    end else begin
      // earliest head release, lowest index on ties
      s = 0;
      for (int i = 1; i < n; i++)
        if (head_leaves[i] < head_leaves[s]) s = i;
      h = head_slot[s];
      ring_times[s][(h + m) % RING] = svc;
      h = (h + 1) % RING;
      head_slot[s] = h[3:0];
      r.start = busy_until[s];
      busy_until[s] = add_sat(r.start, {6'd0, svc});
      head_leaves[s] = add_sat(head_leaves[s], {6'd0, ring_times[s][h]});
    end
    r.server = s[3:0];
    r.finish = busy_until[s];
    r.refused = (r.start >= {5'd0, reg_close});
    return r;
  endfunction

  always @(posedge clk) begin
    dispatch_t want;
    dispatch_t got;
    if (rst) begin
      reg_servers = NUM_SERVERS_RESET;
      reg_depth = QUEUE_DEPTH_RESET;
      reg_open = OPEN_RESET;
      reg_close = CLOSE_RESET;
      clear_servers({5'd0, OPEN_RESET});
      expected_dispatch.delete();
      mismatches = 0;
      outstanding = 0;
    end else begin
      if (out_valid && out_ready) begin
        got.server = server_index;
        got.start = start_time;
        got.finish = finish_time;
        got.refused = refused;
        if (expected_dispatch.size() == 0) begin
          if (mismatches < 10)
            $display("unexpected word: server %0d start %0d finish %0d refused %0b",
                     got.server, got.start, got.finish, got.refused);
          mismatches++;
        end else begin
          want = expected_dispatch.pop_front();
          if (got.server !== want.server || got.start !== want.start ||
              got.finish !== want.finish || got.refused !== want.refused) begin
            if (mismatches < 10)
              $display("mismatch: expected server %0d start %0d finish %0d refused %0b,",
                       want.server, want.start, want.finish, want.refused,
                       " got server %0d start %0d finish %0d refused %0b",
                       got.server, got.start, got.finish, got.refused);
            mismatches++;
          end
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_NUM_SERVERS: reg_servers = cfg_data[4:0];
          CFG_QUEUE_DEPTH: reg_depth = cfg_data[4:0];
          CFG_OPEN_TIME:   reg_open = cfg_data[10:0];
          CFG_CLOSE_TIME:  reg_close = cfg_data[10:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        expected_dispatch.push_back(dispatch_job(new_batch, service_time));
      outstanding = expected_dispatch.size();
    end
  end

endmodule

// File: dv/multi_server_queue_dispatch_tb.sv
module multi_server_queue_dispatch_tb
  import msqd_pkg::*;
();

  localparam int JOB_TARGET = 750;
  localparam int CYCLE_LIMIT = 400000;
  localparam int SETTLE = 32;

  typedef enum int {
    MIX_UNIFORM,
    MIX_SHORT,
    MIX_SATURATE,
    MIX_EDGES
  } job_mix_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic                  new_batch = 1'b0;
  logic [SERVICE_W-1:0]  service_time = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [INDEX_W-1:0]    server_index;
  logic [OUT_TIME_W-1:0] start_time;
  logic [OUT_TIME_W-1:0] finish_time;
  logic                  refused;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int unsigned           mismatches;
  int unsigned           outstanding;
  int                    jobs_sent = 0;
  int                    cycles;
  bit                    idle_on = 1'b1;

  always #5 clk = ~clk;

  multi_server_queue_dispatch u_top (.*);

  msqd_dispatch_checker u_check (.*);

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!idle_on || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic logic [4:0] pick_count();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 5'd0;
      1: return 5'($urandom_range(17, 31));
      2: return 5'd16;
      3: return 5'd1;
      default: return 5'($urandom_range(1, 6));
    endcase
  endfunction

  function automatic logic [10:0] pick_minute();
    int r;
    r = $urandom_range(0, 9);
    case (r)
      0: return 11'd0;
      1: return 11'd2047;
      2: return 11'd1439;
      default: return 11'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic send_job(input logic batch, input logic [SERVICE_W-1:0] svc);
    int gap;
    in_valid <= 1'b1;
    new_batch <= batch;
    service_time <= svc;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    jobs_sent++;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outstanding != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic program_regs(input logic [4:0] ns, input logic [4:0] qd,
                              input logic [10:0] ot, input logic [10:0] ct);
    logic [5:0] pad_a;
    logic [5:0] pad_b;
    pad_a = 6'($urandom);
    pad_b = 6'($urandom);
    cfg_we <= 1'b1;
    cfg_index <= CFG_NUM_SERVERS;
    cfg_data <= {pad_a, ns};
    @(negedge clk);
    cfg_index <= CFG_QUEUE_DEPTH;
    cfg_data <= {pad_b, qd};
    @(negedge clk);
    cfg_index <= CFG_OPEN_TIME;
    cfg_data <= ot;
    @(negedge clk);
    cfg_index <= CFG_CLOSE_TIME;
    cfg_data <= ct;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  // result side back-pressure
  initial begin
    int stall;
    @(negedge rst);
    @(negedge clk);
    forever begin
      if (idle_on && $urandom_range(0, 3) == 0) begin
        stall = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      @(negedge clk);
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("** multi_server_queue_dispatch: FAILED **");
    $finish;
  end

  initial begin
    int phase_len, ns_eff, qd_eff;
    logic [4:0] ns, qd;
    logic [SERVICE_W-1:0] svc;
    job_mix_t mix;
    bit batch;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // four servers, depth two: fill, then pops, then a fresh batch
    program_regs(5'd4, 5'd2, 11'd480, 11'd1020);
    send_job(1'b1, 10'd1023);
    send_job(1'b0, 10'd1);
    send_job(1'b0, 10'd1023);
    send_job(1'b0, 10'd1);
    send_job(1'b0, 10'd500);
    send_job(1'b0, 10'd2);
    send_job(1'b0, 10'd3);
    send_job(1'b0, 10'd4);
    send_job(1'b0, 10'd7);
    send_job(1'b0, 10'd1);
    send_job(1'b0, 10'd1023);
    send_job(1'b1, 10'd600);
    wait_idle();

    // zero counts clamp up; late open, close at zero refuses everything
    program_regs(5'd0, 5'd0, 11'd2047, 11'd0);
    send_job(1'b1, 10'd1023);
    send_job(1'b0, 10'd1023);
    send_job(1'b0, 10'd1);
    wait_idle();

    // oversize counts clamp down
    program_regs(5'd31, 5'd31, 11'd0, 11'd2047);
    send_job(1'b1, 10'd1);
    send_job(1'b0, 10'd1);
    send_job(1'b0, 10'd1023);
    send_job(1'b0, 10'd512);
    wait_idle();

    // equal head releases: ties go to the lowest server
    program_regs(5'd3, 5'd1, 11'd100, 11'd110);
    repeat (6) send_job(1'b0, 10'd5);
    wait_idle();

    while (jobs_sent < JOB_TARGET) begin
      mix = job_mix_t'($urandom_range(0, 3));
      idle_on = ($urandom_range(0, 3) != 0);
      ns = pick_count();
      qd = pick_count();
      if (mix == MIX_SATURATE) ns = 5'd1;
      program_regs(ns, qd, pick_minute(), pick_minute());
      ns_eff = (ns == 0) ? 1 : (ns > 16) ? 16 : int'(ns);
      qd_eff = (qd == 0) ? 1 : (qd > 16) ? 16 : int'(qd);
      phase_len = ns_eff * qd_eff + $urandom_range(5, 40);
      if (mix == MIX_SATURATE) phase_len += 70;
      for (int k = 0; k < phase_len && jobs_sent < JOB_TARGET; k++) begin
        case (mix)
          MIX_UNIFORM: svc = 10'($urandom_range(1, 1023));
          MIX_SHORT:   svc = 10'($urandom_range(1, 8));
          MIX_SATURATE:
            svc = ($urandom_range(0, 9) < 8) ? 10'd1023 : 10'($urandom_range(1, 1023));
          default: begin
            case ($urandom_range(0, 3))
              0: svc = 10'd1;
              1: svc = 10'd1023;
              2: svc = 10'd512;
              default: svc = 10'($urandom_range(1, 1023));
            endcase
          end
        endcase
        batch = (k == 0) || (mix != MIX_SATURATE && $urandom_range(0, 49) == 0);
        send_job(batch, svc);
      end
      wait_idle();
    end

    wait_idle();
    if (mismatches == 0 && outstanding == 0) begin
      $display("** multi_server_queue_dispatch: PASSED **");
    end else begin
      $display("** multi_server_queue_dispatch: FAILED **");
    end
    $finish;
  end

endmodule

// File: multi_server_queue_dispatch.f
+incdir+rtl
rtl/msqd_pkg.sv
rtl/msqd_ram.sv
rtl/msqd_alu.sv
rtl/multi_server_queue_dispatch.sv
rtl/msqd_checker.sv
dv/msqd_dispatch_checker.sv
dv/multi_server_queue_dispatch_tb.sv
